[sv/sce_pkg.sv]
// Shared types, constants and tables for the softmax cross-entropy loss block.
// Used by sce_exp, sce_log, sce_dp, sce_ctrl, the top level and the testbench; depends on nothing.
package sce_pkg;

	localparam int MAX_CLASSES_DEF = 64;
	localparam int EXP_TABLE_BITS_DEF = 8;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_TARGET = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		OUT_OVF,
		OUT_TGT,
		OUT_LOSS,
		OUT_GRAD
	} out_kind_t;

	typedef struct packed {
		logic ld;
		logic ld_last;
		logic clr_run;
		logic idx_clr;
		logic idx_inc;
		logic rd_idx;
		logic rd_tgt;
		logic exp_start;
		logic sum_clr;
		logic sum_add;
		logic log_start;
		logic loss_cap;
		logic div_start;
		logic grad_mul;
		logic out_set;
		out_kind_t out_kind;
	} sce_cmd_t;

	typedef struct packed {
		logic ovf;
		logic tgt_bad;
		logic idx_last;
		logic grad_en;
		logic exp_done;
		logic log_done;
		logic div_done;
		logic out_valid;
	} sce_sts_t;

	// Factors 2^(-2^-m) in Q16, indexed by m - 1.
	function automatic logic [15:0] pow2_frac(input int idx);
		logic [15:0] v;
		case (idx)
			0: v = 16'd46341;
			1: v = 16'd55109;
			2: v = 16'd60097;
			3: v = 16'd62757;
			4: v = 16'd64132;
			5: v = 16'd64830;
			6: v = 16'd65182;
			7: v = 16'd65359;
			8: v = 16'd65447;
			9: v = 16'd65492;
			10: v = 16'd65514;
			default: v = 16'd65525;
		endcase
		return v;
	endfunction

endpackage

[sv/sce_ifs.sv]
// Valid/ready channel interfaces for logits in and results out.
// Standalone; no package dependency.
interface sce_logit_if;
	logic valid;
	logic ready;
	logic signed [15:0] logit;
	logic last_logit;
	logic [5:0] target_class;
	logic signed [15:0] loss_grad;
	modport source(output valid, logit, last_logit, target_class, loss_grad, input ready);
	modport sink(input valid, logit, last_logit, target_class, loss_grad, output ready);
endinterface

interface sce_result_if;
	logic valid;
	logic ready;
	logic [15:0] loss_value;
	logic signed [15:0] grad_value;
	logic [5:0] class_index;
	logic [1:0] error_code;
	logic last_result;
	modport source(output valid, loss_value, grad_value, class_index, error_code, last_result,
		input ready);
	modport sink(input valid, loss_value, grad_value, class_index, error_code, last_result,
		output ready);
endinterface

[sv/sce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[sv/sce_exp.sv]
// Iterative exp(-e) unit: base-2 exponent, one table factor per cycle, final shift.
// Depends on sce_pkg for constants and the factor table.
module sce_exp #(
	parameter int EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] e,
	output logic done,
	output logic [16:0] result
);
	localparam int BW = $clog2(EXP_TABLE_BITS);

	typedef enum logic [1:0] {E_IDLE, E_MUL, E_ITER, E_SHIFT} exp_state_t;

	exp_state_t state_q;
	logic [15:0] e_q;
	logic [32:0] t_q;
	logic [16:0] p_q;
	logic [BW-1:0] b_q;
	logic done_q;
	logic [16:0] result_q;
	logic [8:0] k;
	logic [EXP_TABLE_BITS-1:0] frac;
	logic [33:0] pmul;

	assign k = t_q[32:24];
	assign frac = t_q[23 -: EXP_TABLE_BITS];
	assign pmul = 34'(p_q) * 34'(sce_pkg::pow2_frac(EXP_TABLE_BITS - 1 - int'(b_q)))
		+ 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (start) begin
						state_q <= E_MUL;
					end
				end
				E_MUL: begin
					state_q <= E_ITER;
				end
				E_ITER: begin
					if (k > 9'd16) begin
						done_q <= 1'b1;
						state_q <= E_IDLE;
					end else if (b_q == BW'(EXP_TABLE_BITS - 1)) begin
						state_q <= E_SHIFT;
					end
				end
				E_SHIFT: begin
					done_q <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				e_q <= e;
			end
			E_MUL: begin
				t_q <= 33'(e_q) * 33'(sce_pkg::LOG2E_Q16);
				p_q <= sce_pkg::ONE_Q16;
				b_q <= '0;
			end
			E_ITER: begin
				if (k > 9'd16) begin
					result_q <= '0;
				end else begin
					if (frac[b_q]) begin
						p_q <= pmul[32:16];
					end
					b_q <= b_q + BW'(1);
				end
			end
			E_SHIFT: begin
				result_q <= p_q >> k[4:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = result_q;
endmodule

[sv/sce_log.sv]
// Iterative natural log of a Q16 sum: leading-one search, 16 squaring rounds, ln scale.
// Depends on sce_pkg for the ln 2 constant.
module sce_log (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] s,
	output logic done,
	output logic [15:0] ln
);
	typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_LN, L_OUT} log_state_t;

	log_state_t state_q;
	logic [31:0] r_q;
	logic [3:0] ip_q;
	logic [16:0] m_q;
	logic [3:0] i_q;
	logic [15:0] frac_q;
	logic [35:0] lnp_q;
	logic [15:0] ln_q;
	logic done_q;
	logic [33:0] sq;

	assign sq = 34'(m_q) * 34'(m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: if (start) state_q <= L_NORM;
				L_NORM: if (r_q[31:17] == '0) state_q <= L_SQ;
				L_SQ: if (i_q == 4'd15) state_q <= L_LN;
				L_LN: state_q <= L_OUT;
				L_OUT: begin
					done_q <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				r_q <= s;
				ip_q <= '0;
			end
			L_NORM: begin
				if (r_q[31:17] != '0) begin
					r_q <= r_q >> 1;
					ip_q <= ip_q + 4'd1;
				end else begin
					m_q <= r_q[16:0];
					i_q <= '0;
					frac_q <= '0;
				end
			end
			L_SQ: begin
				if (sq[33]) begin
					m_q <= sq[33:17];
					frac_q[~i_q] <= 1'b1;
				end else begin
					m_q <= sq[32:16];
				end
				i_q <= i_q + 4'd1;
			end
			L_LN: begin
				lnp_q <= 36'({ip_q, frac_q}) * 36'(sce_pkg::LN2_Q16) + 36'(1 << 23);
			end
			L_OUT: begin
				ln_q <= 16'(lnp_q >> 24);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign ln = ln_q;
endmodule

[sv/sce_div.sv]
// Restoring divider, one quotient bit per cycle, for the softmax probability.
// No dependencies.
module sce_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [32:0] num,
	input logic [31:0] den,
	output logic done,
	output logic [16:0] quo
);
	typedef enum logic {D_IDLE, D_RUN} div_state_t;

	div_state_t state_q;
	logic [32:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [16:0] quo_q;
	logic [5:0] cnt_q;
	logic done_q;
	logic [32:0] trial;
	logic take;

	assign trial = {rem_q, num_q[32]};
	assign take = trial >= 33'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: if (start) state_q <= D_RUN;
				D_RUN: begin
					if (cnt_q == 6'd32) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= '0;
			end
			D_RUN: begin
				rem_q <= take ? 32'(trial - 33'(den_q)) : trial[31:0];
				quo_q <= {quo_q[15:0], take};
				num_q <= num_q << 1;
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

[sv/sce_dp.sv]
// Datapath: logit store, run registers, exp/log/divide units, gradient and result register.
// Depends on sce_pkg, sce_ram, sce_exp, sce_log and sce_div.
module sce_dp #(
	parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF,
	parameter int EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic signed [15:0] logit,
	input logic [5:0] target_class,
	input logic signed [15:0] loss_grad,
	input sce_pkg::sce_cmd_t cmd,
	output sce_pkg::sce_sts_t sts,
	input logic out_ready,
	output logic out_valid,
	output logic [15:0] loss_value,
	output logic signed [15:0] grad_value,
	output logic [5:0] class_index,
	output logic [1:0] error_code,
	output logic last_result
);
	localparam int IW = $clog2(MAX_CLASSES);
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int TW = (CW > 6) ? CW : 6;

	logic [CW-1:0] count_q;
	logic signed [15:0] max_q;
	logic ovf_q;
	logic grad_en_q;
	logic [31:0] sum_q;
	logic [IW-1:0] idx_q;
	logic [5:0] tgt_q;
	logic signed [15:0] up_q;
	logic [15:0] loss_q;
	logic signed [34:0] prod_q;
	logic out_valid_q;
	logic [15:0] loss_out_q;
	logic signed [15:0] grad_out_q;
	logic [5:0] cls_out_q;
	logic [1:0] err_out_q;
	logic last_out_q;

	logic room;
	logic ram_we;
	logic [IW-1:0] raddr;
	logic [15:0] ram_rdata;
	logic signed [15:0] x_rd;
	logic [16:0] diff;
	logic [17:0] lsum;
	logic [16:0] ev;
	logic exp_done;
	logic [15:0] ln;
	logic log_done;
	logic [16:0] quo;
	logic div_done;
	logic is_tgt;
	logic signed [17:0] g;
	logic signed [18:0] q19;
	logic signed [15:0] grad_sat;
	logic idx_last;

	assign room = count_q < CW'(MAX_CLASSES);
	assign ram_we = cmd.ld && room;
	assign raddr = cmd.rd_tgt ? IW'(tgt_q) : idx_q;
	assign x_rd = signed'(ram_rdata);
	assign diff = {max_q[15], max_q} - {x_rd[15], x_rd};
	assign lsum = 18'(diff) + 18'(ln);
	assign is_tgt = idx_q == IW'(tgt_q);
	assign g = signed'({1'b0, quo}) - (is_tgt ? 18'sd65536 : 18'sd0);
	assign q19 = prod_q[34:16];
	assign idx_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_comb begin
		if (q19 > 19'sd32767) begin
			grad_sat = 16'sh7FFF;
		end else if (q19 < -19'sd32768) begin
			grad_sat = -16'sh8000;
		end else begin
			grad_sat = q19[15:0];
		end
	end

	sce_ram #(
		.WIDTH(16),
		.DEPTH(MAX_CLASSES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata(logit),
		.re(cmd.rd_idx || cmd.rd_tgt),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	sce_exp #(
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.exp_start),
		.e(diff[15:0]),
		.done(exp_done),
		.result(ev)
	);

	sce_log u_log (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.log_start),
		.s(sum_q),
		.done(log_done),
		.ln(ln)
	);

	sce_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num({ev, 16'h0000} + 33'(sum_q[31:1])),
		.den(sum_q),
		.done(div_done),
		.quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q <= -16'sh8000;
			ovf_q <= 1'b0;
			grad_en_q <= 1'b1;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				grad_en_q <= cfg_wdata;
			end
			if (cmd.clr_run) begin
				count_q <= '0;
				max_q <= -16'sh8000;
				ovf_q <= 1'b0;
				sum_q <= '0;
			end else if (cmd.ld) begin
				if (room) begin
					count_q <= count_q + CW'(1);
					if (logit > max_q) begin
						max_q <= logit;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.sum_clr) begin
				sum_q <= '0;
			end else if (cmd.sum_add) begin
				sum_q <= sum_q + 32'(ev);
			end
			if (cmd.out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_last) begin
			tgt_q <= target_class;
			up_q <= loss_grad;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.loss_cap) begin
			loss_q <= (lsum > 18'd65535) ? 16'hFFFF : lsum[15:0];
		end
		if (cmd.grad_mul) begin
			prod_q <= 35'(g) * 35'(up_q) + 35'sd32768;
		end
		if (cmd.out_set) begin
			case (cmd.out_kind)
				sce_pkg::OUT_OVF: begin
					loss_out_q <= '0;
					grad_out_q <= '0;
					cls_out_q <= '0;
					err_out_q <= sce_pkg::ERR_OVERFLOW;
					last_out_q <= 1'b1;
				end
				sce_pkg::OUT_TGT: begin
					loss_out_q <= '0;
					grad_out_q <= '0;
					cls_out_q <= '0;
					err_out_q <= sce_pkg::ERR_TARGET;
					last_out_q <= 1'b1;
				end
				sce_pkg::OUT_LOSS: begin
					loss_out_q <= loss_q;
					grad_out_q <= '0;
					cls_out_q <= '0;
					err_out_q <= sce_pkg::ERR_OK;
					last_out_q <= 1'b1;
				end
				default: begin
					loss_out_q <= loss_q;
					grad_out_q <= grad_sat;
					cls_out_q <= 6'(idx_q);
					err_out_q <= sce_pkg::ERR_OK;
					last_out_q <= idx_last;
				end
			endcase
		end
	end

	assign sts.ovf = ovf_q;
	assign sts.tgt_bad = TW'(tgt_q) >= TW'(count_q);
	assign sts.idx_last = idx_last;
	assign sts.grad_en = grad_en_q;
	assign sts.exp_done = exp_done;
	assign sts.log_done = log_done;
	assign sts.div_done = div_done;
	assign sts.out_valid = out_valid_q;

	assign out_valid = out_valid_q;
	assign loss_value = loss_out_q;
	assign grad_value = grad_out_q;
	assign class_index = cls_out_q;
	assign error_code = err_out_q;
	assign last_result = last_out_q;
endmodule

[sv/sce_ctrl.sv]
// Controller state machine that sequences loading, the exp sum, log, loss and gradient passes.
// Depends on sce_pkg for the command and status structs.
module sce_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_last,
	output logic in_ready,
	input sce_pkg::sce_sts_t sts,
	output sce_pkg::sce_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_SUM_RD,
		S_SUM_EXP,
		S_SUM_WAIT,
		S_LOG,
		S_LOG_WAIT,
		S_LOSS,
		S_LOSS_OUT,
		S_GRD_RD,
		S_GRD_EXP,
		S_GRD_WAIT,
		S_GRD_DIV,
		S_GRD_OUT,
		S_GRD_EMIT,
		S_EMIT_END
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.ld = 1'b1;
					if (in_last) begin
						cmd.ld_last = 1'b1;
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (sts.ovf) begin
					cmd.out_set = 1'b1;
					cmd.out_kind = sce_pkg::OUT_OVF;
					state_d = S_EMIT_END;
				end else if (sts.tgt_bad) begin
					cmd.out_set = 1'b1;
					cmd.out_kind = sce_pkg::OUT_TGT;
					state_d = S_EMIT_END;
				end else begin
					cmd.idx_clr = 1'b1;
					cmd.sum_clr = 1'b1;
					state_d = S_SUM_RD;
				end
			end
			S_SUM_RD: begin
				cmd.rd_idx = 1'b1;
				state_d = S_SUM_EXP;
			end
			S_SUM_EXP: begin
				cmd.exp_start = 1'b1;
				state_d = S_SUM_WAIT;
			end
			S_SUM_WAIT: begin
				if (sts.exp_done) begin
					cmd.sum_add = 1'b1;
					if (sts.idx_last) begin
						state_d = S_LOG;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_SUM_RD;
					end
				end
			end
			S_LOG: begin
				cmd.log_start = 1'b1;
				state_d = S_LOG_WAIT;
			end
			S_LOG_WAIT: begin
				if (sts.log_done) begin
					cmd.rd_tgt = 1'b1;
					state_d = S_LOSS;
				end
			end
			S_LOSS: begin
				cmd.loss_cap = 1'b1;
				if (sts.grad_en) begin
					cmd.idx_clr = 1'b1;
					state_d = S_GRD_RD;
				end else begin
					state_d = S_LOSS_OUT;
				end
			end
			S_LOSS_OUT: begin
				cmd.out_set = 1'b1;
				cmd.out_kind = sce_pkg::OUT_LOSS;
				state_d = S_EMIT_END;
			end
			S_GRD_RD: begin
				cmd.rd_idx = 1'b1;
				state_d = S_GRD_EXP;
			end
			S_GRD_EXP: begin
				cmd.exp_start = 1'b1;
				state_d = S_GRD_WAIT;
			end
			S_GRD_WAIT: begin
				if (sts.exp_done) begin
					cmd.div_start = 1'b1;
					state_d = S_GRD_DIV;
				end
			end
			S_GRD_DIV: begin
				if (sts.div_done) begin
					cmd.grad_mul = 1'b1;
					state_d = S_GRD_OUT;
				end
			end
			S_GRD_OUT: begin
				cmd.out_set = 1'b1;
				cmd.out_kind = sce_pkg::OUT_GRAD;
				state_d = S_GRD_EMIT;
			end
			S_GRD_EMIT: begin
				if (!sts.out_valid) begin
					if (sts.idx_last) begin
						cmd.clr_run = 1'b1;
						state_d = S_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_GRD_RD;
					end
				end
			end
			S_EMIT_END: begin
				if (!sts.out_valid) begin
					cmd.clr_run = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_LOAD;
endmodule

[sv/softmax_cross_entropy_loss.sv]
// Softmax cross-entropy loss with per-class gradient, Q8.8 fixed point.
// Loading takes one logit per cycle. After the last logit, the exp pass runs the exp unit
// once per class, then the log unit runs once with a normalizing shift search, and each
// gradient runs the exp unit and then the 33-step divider.
// Reset clears the run state, sets the gradient enable (grad_en) to 1 and leaves the logit store undefined.
module softmax_cross_entropy_loss #(
	parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF,
	parameter int EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	sce_logit_if.sink logits,
	sce_result_if.source results
);
	sce_pkg::sce_cmd_t cmd;
	sce_pkg::sce_sts_t sts;

	sce_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(logits.valid),
		.in_last(logits.last_logit),
		.in_ready(logits.ready),
		.sts(sts),
		.cmd(cmd)
	);

	sce_dp #(
		.MAX_CLASSES(MAX_CLASSES),
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.logit(logits.logit),
		.target_class(logits.target_class),
		.loss_grad(logits.loss_grad),
		.cmd(cmd),
		.sts(sts),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.loss_value(results.loss_value),
		.grad_value(results.grad_value),
		.class_index(results.class_index),
		.error_code(results.error_code),
		.last_result(results.last_result)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(logits.ready && results.valid))
		else $error("Input accepted while a result is pending.");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.error_code != sce_pkg::ERR_OK |-> results.last_result)
		else $error("Error result not marked as the last result.");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		logits.valid && logits.ready && logits.last_logit |=> !logits.ready)
		else $error("Input still ready after the last logit.");
`endif
endmodule

[verif/softmax_cross_entropy_loss_tb.sv]
// Testbench for the softmax cross-entropy loss block: drives logit vectors, predicts
// the loss and per-class gradients in fixed point, and checks every result transaction.
// Depends on sce_pkg, the channel interfaces and the softmax_cross_entropy_loss RTL.
module softmax_cross_entropy_loss_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] loss;
		logic [15:0] grad;
		logic [5:0] cls;
		logic [1:0] err;
		logic last;
	} sce_res_t;

	class loss_scoreboard;
		logic signed [15:0] vec[$];
		logic signed [15:0] vmax;
		bit ovf;
		bit grad_on;
		sce_res_t pending[$];
		int errors;
		int checked;

		function new();
			vmax = -16'sd32768;
			ovf = 0;
			grad_on = 1;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] exp_neg(logic [31:0] e);
			logic [63:0] t;
			logic [63:0] p;
			logic [63:0] k;
			logic [31:0] fr;
			t = 64'(e) * 64'd94548;
			k = t >> 24;
			p = 64'd65536;
			if (k > 16) return 0;
			fr = 32'((t >> (24 - 8)) & 64'hFF);
			for (int b = 0; b < 8; b++)
				if (fr[b]) p = (p * 64'(sce_pkg::pow2_frac(7 - b)) + 64'd32768) >> 16;
			return 32'(p >> k);
		endfunction

		function logic [31:0] log2q(logic [31:0] s);
			int pos;
			logic [63:0] m;
			logic [31:0] fr;
			pos = 16;
			fr = 0;
			while (pos < 31 && (s >> (pos + 1)) != 0) pos++;
			m = 64'(s >> (pos - 16));
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 16;
				if (m >= 64'd131072) begin
					m = m >> 1;
					fr[15 - i] = 1'b1;
				end
			end
			return (32'(pos - 16) << 16) | fr;
		endfunction

		function void clear();
			vec.delete();
			vmax = -16'sd32768;
			ovf = 0;
		endfunction

		function void note_input(logic signed [15:0] x, bit last, logic [5:0] tgt,
				logic signed [15:0] up);
			int n;
			logic [31:0] sum;
			logic [31:0] ev;
			logic [63:0] lnq;
			longint ls;
			logic [15:0] loss;
			longint p;
			longint g;
			longint q;
			if (vec.size() < 64) begin
				vec.push_back(x);
				if (x > vmax) vmax = x;
			end else ovf = 1;
			if (!last) return;
			n = vec.size();
			if (ovf) begin
				pending.push_back('{0, 0, 0, sce_pkg::ERR_OVERFLOW, 1});
				clear();
				return;
			end
			if (tgt >= n) begin
				pending.push_back('{0, 0, 0, sce_pkg::ERR_TARGET, 1});
				clear();
				return;
			end
			sum = 0;
			foreach (vec[i]) sum += exp_neg(32'(int'(vmax) - int'(vec[i])));
			lnq = (64'(log2q(sum)) * 64'd45426 + 64'd8388608) >> 24;
			ls = longint'(vmax) - longint'(vec[tgt]) + longint'(lnq);
			loss = ls > 65535 ? 16'hFFFF : 16'(ls);
			if (!grad_on) begin
				pending.push_back('{loss, 0, 0, sce_pkg::ERR_OK, 1});
				clear();
				return;
			end
			for (int i = 0; i < n; i++) begin
				ev = exp_neg(32'(int'(vmax) - int'(vec[i])));
				p = longint'(((64'(ev) << 16) + 64'(sum / 2)) / 64'(sum));
				g = p - (i == tgt ? 65536 : 0);
				q = g * longint'(up) + 32768;
				q = q >>> 16;
				if (q > 32767) q = 32767;
				if (q < -32768) q = -32768;
				pending.push_back('{loss, 16'(q), 6'(i), sce_pkg::ERR_OK, i == n - 1});
			end
			clear();
		endfunction

		task report(string what);
			errors++;
			$display("error @%0t: %s", $time, what);
		endtask

		task check_result(sce_res_t got);
			sce_res_t want;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending.pop_front();
			if (got.loss !== want.loss) report($sformatf("loss %0d want %0d", got.loss, want.loss));
			if (got.grad !== want.grad)
				report($sformatf("grad %0d want %0d", $signed(got.grad), $signed(want.grad)));
			if (got.cls !== want.cls) report($sformatf("class %0d want %0d", got.cls, want.cls));
			if (got.err !== want.err) report($sformatf("error %0d want %0d", got.err, want.err));
			if (got.last !== want.last) report($sformatf("last %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_wdata = 0;
	int src_idle = 0;
	int snk_stall = 0;
	int vectors = 0;

	sce_logit_if logits();
	sce_result_if results();
	loss_scoreboard sb = new();

	softmax_cross_entropy_loss dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.logits(logits.sink), .results(results.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		logits.valid = 0;
		logits.logit = 0;
		logits.last_logit = 0;
		logits.target_class = 0;
		logits.loss_grad = 0;
		results.ready = 0;
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			sb.check_result('{results.loss_value, results.grad_value, results.class_index,
				results.error_code, results.last_result});
		results.ready <= ($urandom_range(99) >= snk_stall);
	end

	// Valid stays high after an accept so that a following transaction can go back to back;
	// it is dropped in idle cycles and before any wait.
	task send_logit(logic signed [15:0] x, bit last, logic [5:0] tgt, logic signed [15:0] up);
		while ($urandom_range(99) < src_idle) begin
			logits.valid <= 0;
			@(posedge clk);
		end
		logits.valid <= 1;
		logits.logit <= x;
		logits.last_logit <= last;
		logits.target_class <= tgt;
		logits.loss_grad <= up;
		@(posedge clk);
		while (!logits.ready) @(posedge clk);
		sb.note_input(x, last, tgt, up);
		if (last) vectors++;
	endtask

	task send_vector(int n, logic [5:0] tgt, logic signed [15:0] up, int spread);
		logic signed [15:0] x;
		for (int i = 0; i < n; i++) begin
			x = (spread == 0) ? 16'($urandom) : 16'($urandom_range(2 * spread) - spread);
			send_logit(x, i == n - 1, tgt, up);
		end
	endtask

	task drain();
		logits.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	task set_grad(bit v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.grad_on = v;
	endtask

	task random_phase(int count);
		int n;
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			n = (r < 5) ? 64 : $urandom_range(1, 6);
			if (r < 8) send_vector(n, 6'($urandom), 16'($urandom), 0);
			else if (r < 11) send_vector(65 + $urandom_range(2), 6'($urandom), 16'($urandom), 0);
			else send_vector(n, 6'($urandom_range(n - 1)), 16'($urandom),
				($urandom_range(1)) ? 600 : 30000);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_logit(16'sh7FFF, 0, 0, 0);
		send_logit(-16'sd32768, 1, 0, 16'sh7FFF);
		send_logit(0, 1, 0, -16'sd32768);
		send_logit(100, 0, 0, 0);
		send_logit(100, 1, 1, 16'sh0100);
		send_logit(5, 0, 63, 0);
		send_logit(7, 1, 2, 16'sh0100);
		send_vector(64, 63, 16'shFFFF, 0);
		send_vector(65, 0, 16'sh0100, 0);
		send_vector(3, 2, -16'sd32768, 0);
		set_grad(0);
		send_logit(-16'sd32768, 0, 0, 0);
		send_logit(16'sh7FFF, 1, 0, 16'sh0100);
		send_vector(2, 5, 0, 0);
		send_vector(3, 1, 16'sh5555, 200);
		set_grad(1);
		random_phase(3);
		src_idle = 48;
		random_phase(3);
		drain();
		src_idle = 0;
		snk_stall = 48;
		random_phase(3);
		set_grad(0);
		src_idle = 18;
		snk_stall = 18;
		random_phase(3);
		set_grad(1);
		random_phase(3);
		drain();
		$display("Covered %0d vectors and %0d result transactions across idle/stall phases,",
			vectors, sb.checked);
		$display("both gradient settings, overflow and bad-target runs.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#60ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
